/* sv/pbfm_pkg.sv */
// Package for the packed bit-field matrix unit.
// Holds field widths, command and register codes, and the sequencer state type.
// No dependencies.
package pbfm_pkg;

  localparam int unsigned BYTE_BITS = 8;
  localparam int unsigned COL_W     = 15;
  localparam int unsigned ROW_W     = 15;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned CNT_W     = 16;
  localparam int unsigned KEY_W     = 6;
  localparam int unsigned PADDR_W   = 4;
  localparam int unsigned PDATA_W   = 32;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam logic [1:0] REG_COLUMN_COUNT = 2'd0;
  localparam logic [1:0] REG_ROW_COUNT    = 2'd1;
  localparam logic [1:0] REG_KEY_BITS     = 2'd2;

  localparam logic [CNT_W-1:0] COLUMN_COUNT_RST = 16'd64;
  localparam logic [CNT_W-1:0] ROW_COUNT_RST    = 16'd64;
  localparam logic [KEY_W-1:0] KEY_BITS_RST     = 6'd8;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL_PITCH,
    ST_MUL_BIT,
    ST_MUL_ROW,
    ST_ADDR,
    ST_RD,
    ST_MOD,
    ST_DONE
  } state_e;

  // Clamp the field width to 1..32.
  function automatic logic [KEY_W-1:0] eff_key(input logic [KEY_W-1:0] key);
    logic [KEY_W-1:0] k;
    k = key;
    if (key == '0) begin
      k = 6'd1;
    end else if (key > 6'd32) begin
      k = 6'd32;
    end
    return k;
  endfunction

endpackage

/* sv/pbfm_if.sv */
// Request and response channel interfaces of the packed bit-field matrix unit.
// Depends on pbfm_pkg for field widths.
interface pbfm_req_if;
  logic                           valid;
  logic                           ready;
  logic                           command;
  logic [pbfm_pkg::COL_W-1:0]     column;
  logic [pbfm_pkg::ROW_W-1:0]     row;
  logic [pbfm_pkg::VAL_W-1:0]     write_value;

  modport source (output valid, command, column, row, write_value, input ready);
  modport sink   (input valid, command, column, row, write_value, output ready);
endinterface

interface pbfm_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [pbfm_pkg::VAL_W-1:0]     read_value;
  logic                           out_of_range;

  modport source (output valid, read_value, out_of_range, input ready);
  modport sink   (input valid, read_value, out_of_range, output ready);
endinterface

/* sv/packed_bit_field_matrix_unit.sv */
// Packed bit-field matrix unit: field read and read-modify-write over a byte store.
// Depends on pbfm_pkg, pbfm_req_if, pbfm_rsp_if and pbfm_ram.
//
// Use: a request on req_i carries command, column, row and write_value; it is
// taken when valid and ready are both high. Each request gives exactly one
// response on rsp_o (read_value, out_of_range), held until ready is high.
// The APB port sets column_count (0x0), row_count (0x4) and key_bits (0x8);
// write it only while no request is in flight.
// Sequence: address math runs in MUL_PITCH, MUL_BIT, MUL_ROW and ADDR on one
// shared multiplier, then RD and MOD repeat for each byte the field touches
// (read, then modify and write back on the byte-wide RAM), then DONE; a
// rejected access goes from ADDR to DONE. ready is high only while the
// sequencer is idle, so a request is taken only after the last has left DONE.
// Reset: a clearing pass writes zero to every byte with ready low; registers
// return to 64, 64 and 8.
// Stall: a finished response waits in the output register; the next request
// is taken meanwhile, and its result waits until the register frees.
module packed_bit_field_matrix_unit #(
  parameter int unsigned MEM_BYTES = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  pbfm_req_if.sink                      req_i,
  pbfm_rsp_if.source                    rsp_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pbfm_pkg::PADDR_W-1:0]  paddr,
  input  logic [pbfm_pkg::PDATA_W-1:0]  pwdata,
  output logic [pbfm_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  localparam int unsigned AW    = $clog2(MEM_BYTES);
  localparam int unsigned IDX_W = 36;
  localparam logic [IDX_W-1:0] MEM_LIMIT = IDX_W'(MEM_BYTES);
  localparam logic [AW-1:0]    CLR_LAST  = AW'(MEM_BYTES - 1);

  pbfm_pkg::state_e state_q, state_d;

  // Configuration
  logic [pbfm_pkg::CNT_W-1:0] column_count_q, row_count_q;
  logic [pbfm_pkg::KEY_W-1:0] key_bits_q, kb;
  logic                       cfg_wr;

  // Request payload
  logic                       cmd_q;
  logic [pbfm_pkg::COL_W-1:0] col_q;
  logic [pbfm_pkg::ROW_W-1:0] row_q;
  logic [pbfm_pkg::VAL_W-1:0] wval_q;

  // Address math
  logic [17:0] mul_a;
  logic [15:0] mul_b;
  logic [33:0] prod_q;
  logic [17:0] pitch_q;
  logic [20:0] bitpos_q;
  logic [20:0] pitch_sum;
  logic [IDX_W-1:0] idx, last;
  logic [6:0]  span;
  logic        oor;

  // Byte loop
  logic [AW-1:0]  addr_q, last_q, clr_q;
  logic [2:0]     off_q;
  logic [5:0]     left_q, done_q;
  logic [31:0]    result_q;
  logic           oor_q;
  logic [3:0]     room, chunk;
  logic [8:0]     mask9;
  logic [7:0]     mask, piece, got, new_byte, rd_byte;
  logic [2:0]     shift;

  // RAM port
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;

  // Output register
  logic        out_valid_q;
  logic [31:0] out_value_q;
  logic        out_oor_q;
  logic        out_load;

  assign kb = pbfm_pkg::eff_key(key_bits_q);

  // APB
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      pbfm_pkg::REG_COLUMN_COUNT: prdata = 32'(column_count_q);
      pbfm_pkg::REG_ROW_COUNT:    prdata = 32'(row_count_q);
      pbfm_pkg::REG_KEY_BITS:     prdata = 32'(key_bits_q);
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_count_q <= pbfm_pkg::COLUMN_COUNT_RST;
      row_count_q    <= pbfm_pkg::ROW_COUNT_RST;
      key_bits_q     <= pbfm_pkg::KEY_BITS_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        pbfm_pkg::REG_COLUMN_COUNT: column_count_q <= pwdata[15:0];
        pbfm_pkg::REG_ROW_COUNT:    row_count_q    <= pwdata[15:0];
        pbfm_pkg::REG_KEY_BITS:     key_bits_q     <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      pbfm_pkg::ST_MUL_PITCH: begin
        mul_a = 18'(column_count_q);
        mul_b = 16'(kb);
      end
      pbfm_pkg::ST_MUL_BIT: begin
        mul_a = 18'(col_q);
        mul_b = 16'(kb);
      end
      pbfm_pkg::ST_MUL_ROW: begin
        mul_a = pitch_q;
        mul_b = 16'(row_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign pitch_sum = prod_q[20:0] + 21'd7;
  assign idx  = IDX_W'(prod_q) + IDX_W'(bitpos_q[20:3]);
  assign span = 7'(bitpos_q[2:0]) + 7'(kb) - 7'd1;
  assign last = idx + IDX_W'(span[6:3]);
  assign oor  = ({1'b0, col_q} >= column_count_q) || ({1'b0, row_q} >= row_count_q) ||
                (last >= MEM_LIMIT);

  // Byte chunk
  assign rd_byte  = 8'(0);
  assign room     = 4'd8 - {1'b0, off_q};
  assign chunk    = (left_q < 6'(room)) ? left_q[3:0] : room;
  assign mask9    = (9'd1 << chunk) - 9'd1;
  assign mask     = mask9[7:0];
  assign shift    = 3'(4'd8 - chunk - {1'b0, off_q});

  logic [7:0] ram_rdata;
  assign piece    = 8'(wval_q >> done_q) & mask;
  assign new_byte = (ram_rdata & ~(mask << shift)) | (piece << shift);
  assign got      = (ram_rdata >> shift) & mask;

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pbfm_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    req_i.ready = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = addr_q;
    ram_wdata   = new_byte;
    out_load    = 1'b0;
    unique case (state_q)
      pbfm_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = rd_byte;
        if (clr_q == CLR_LAST) begin
          state_d = pbfm_pkg::ST_IDLE;
        end
      end
      pbfm_pkg::ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          state_d = pbfm_pkg::ST_MUL_PITCH;
        end
      end
      pbfm_pkg::ST_MUL_PITCH: state_d = pbfm_pkg::ST_MUL_BIT;
      pbfm_pkg::ST_MUL_BIT:   state_d = pbfm_pkg::ST_MUL_ROW;
      pbfm_pkg::ST_MUL_ROW:   state_d = pbfm_pkg::ST_ADDR;
      pbfm_pkg::ST_ADDR: begin
        state_d = oor ? pbfm_pkg::ST_DONE : pbfm_pkg::ST_RD;
      end
      pbfm_pkg::ST_RD: state_d = pbfm_pkg::ST_MOD;
      pbfm_pkg::ST_MOD: begin
        ram_we  = (cmd_q == pbfm_pkg::CMD_WRITE);
        state_d = (left_q == 6'(chunk)) ? pbfm_pkg::ST_DONE : pbfm_pkg::ST_RD;
      end
      pbfm_pkg::ST_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = pbfm_pkg::ST_IDLE;
        end
      end
      default: state_d = pbfm_pkg::ST_IDLE;
    endcase
  end

  // Clear counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (state_q == pbfm_pkg::ST_CLEAR) begin
      clr_q <= clr_q + AW'(1);
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      pbfm_pkg::ST_IDLE: begin
        if (req_i.valid) begin
          cmd_q  <= req_i.command;
          col_q  <= req_i.column;
          row_q  <= req_i.row;
          wval_q <= req_i.write_value;
        end
      end
      pbfm_pkg::ST_MUL_PITCH: prod_q <= mul_a * mul_b;
      pbfm_pkg::ST_MUL_BIT: begin
        pitch_q <= 18'(pitch_sum[20:3]);
        prod_q  <= mul_a * mul_b;
      end
      pbfm_pkg::ST_MUL_ROW: begin
        bitpos_q <= prod_q[20:0];
        prod_q   <= mul_a * mul_b;
      end
      pbfm_pkg::ST_ADDR: begin
        addr_q   <= idx[AW-1:0];
        last_q   <= last[AW-1:0];
        off_q    <= bitpos_q[2:0];
        left_q   <= kb;
        done_q   <= '0;
        result_q <= '0;
        oor_q    <= oor;
      end
      pbfm_pkg::ST_MOD: begin
        if (cmd_q == pbfm_pkg::CMD_READ) begin
          result_q <= result_q | (32'(got) << done_q);
        end
        done_q <= done_q + 6'(chunk);
        left_q <= left_q - 6'(chunk);
        addr_q <= addr_q + AW'(1);
        off_q  <= '0;
      end
      default: ;
    endcase
  end

  pbfm_ram #(
    .WIDTH (pbfm_pkg::BYTE_BITS),
    .DEPTH (MEM_BYTES)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (ram_waddr),
    .wr_data_i (ram_wdata),
    .rd_addr_i (addr_q),
    .rd_data_o (ram_rdata)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_value_q <= result_q;
      out_oor_q   <= oor_q;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.read_value   = out_value_q;
  assign rsp_o.out_of_range = out_oor_q;

  // Assertions
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.out_of_range) |-> (rsp_o.read_value == '0))
    else $error("rejected access returned nonzero data");

  a_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(rsp_o.valid) && $past(cmd_q) == pbfm_pkg::CMD_WRITE) |-> (rsp_o.read_value == '0))
    else $error("write returned nonzero data");

  a_mod_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pbfm_pkg::ST_MOD) |-> (left_q != '0 && addr_q <= last_q))
    else $error("byte loop ran past the field");

  a_ram_we: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == pbfm_pkg::ST_CLEAR ||
                (state_q == pbfm_pkg::ST_MOD && !oor_q)))
    else $error("byte store written outside clear or accepted write");

endmodule

/* sv/pbfm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pbfm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

/* bench/packed_bit_field_matrix_unit_tb.sv */
// Self-checking bench for packed_bit_field_matrix_unit: field reads and writes
// across many matrix shapes, checked against a byte-level mirror of the store.
// Depends on pbfm_pkg, pbfm_req_if, pbfm_rsp_if and the unit itself.
module packed_bit_field_matrix_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STORE_BYTES  = 4096;
  localparam int unsigned RANDOM_ITEMS = 1700;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned PLAN_ROWS    = 25;
  localparam logic [1:0]  REG_SPARE    = 2'd3;

  typedef struct packed {
    logic [pbfm_pkg::VAL_W-1:0] read_value;
    logic                       out_of_range;
  } field_result_t;

  typedef struct packed {
    logic [pbfm_pkg::CNT_W-1:0] cc;
    logic [pbfm_pkg::CNT_W-1:0] rr;
    logic [pbfm_pkg::KEY_W-1:0] kb;
    logic                       cmd;
    logic [pbfm_pkg::COL_W-1:0] col;
    logic [pbfm_pkg::ROW_W-1:0] row;
    logic [pbfm_pkg::VAL_W-1:0] val;
    logic                       fixed;
    logic [pbfm_pkg::VAL_W-1:0] want;
    logic                       want_oor;
  } plan_row_t;

  logic clk;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [pbfm_pkg::PADDR_W-1:0] paddr;
  logic [pbfm_pkg::PDATA_W-1:0] pwdata;
  logic [pbfm_pkg::PDATA_W-1:0] prdata;
  logic pready;

  pbfm_req_if req ();
  pbfm_rsp_if rsp ();

  packed_bit_field_matrix_unit #(
    .MEM_BYTES(STORE_BYTES)
  ) DUT (
    .clk_i  (clk),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  logic [7:0]                 byte_image [STORE_BYTES];
  logic [pbfm_pkg::CNT_W-1:0] cfg_columns;
  logic [pbfm_pkg::CNT_W-1:0] cfg_rows;
  logic [pbfm_pkg::KEY_W-1:0] cfg_key;
  field_result_t              pending_fields [$];
  plan_row_t                  plan [PLAN_ROWS];
  field_result_t              front_field;
  bit                         quiet;
  int unsigned                failures;
  int unsigned                reads_sent;
  int unsigned                writes_sent;
  int unsigned                rejects_sent;
  int unsigned                settings_done;
  int unsigned                cycle_count;

  function automatic int unsigned eff_width(input logic [pbfm_pkg::KEY_W-1:0] key);
    if (key == '0) return 1;
    if (key > 6'd32) return 32;
    return int'(key);
  endfunction

  function automatic longint unsigned row_pitch(input logic [pbfm_pkg::CNT_W-1:0] cols,
                                                input int unsigned width);
    return (64'(cols) * width + 7) / pbfm_pkg::BYTE_BITS;
  endfunction

  function automatic field_result_t field_access(input logic cmd,
                                                 input logic [pbfm_pkg::COL_W-1:0] col,
                                                 input logic [pbfm_pkg::ROW_W-1:0] row,
                                                 input logic [pbfm_pkg::VAL_W-1:0] wval);
    field_result_t              r;
    int unsigned                width, off, left, done, chunk, shift;
    longint unsigned            bitpos, addr, last;
    logic [pbfm_pkg::VAL_W-1:0] mask, acc;
    logic [7:0]                 cur;
    width  = eff_width(cfg_key);
    bitpos = 64'(col) * width;
    addr   = 64'(row) * row_pitch(cfg_columns, width) + bitpos / pbfm_pkg::BYTE_BITS;
    off    = int'(bitpos % pbfm_pkg::BYTE_BITS);
    last   = addr + (off + width - 1) / pbfm_pkg::BYTE_BITS;
    r = '0;
    if (col >= cfg_columns || row >= cfg_rows || last >= STORE_BYTES) begin
      r.out_of_range = 1'b1;
      return r;
    end
    left = width;
    done = 0;
    acc  = '0;
    while (left > 0) begin
      chunk = (left < pbfm_pkg::BYTE_BITS - off) ? left : pbfm_pkg::BYTE_BITS - off;
      mask  = (32'd1 << chunk) - 32'd1;
      shift = pbfm_pkg::BYTE_BITS - chunk - off;
      cur   = byte_image[addr];
      if (cmd == pbfm_pkg::CMD_WRITE) begin
        cur = (cur & ~8'(mask << shift)) | 8'(((wval >> done) & mask) << shift);
        byte_image[addr] = cur;
      end else begin
        acc |= ((32'(cur) >> shift) & mask) << done;
      end
      done += chunk;
      left -= chunk;
      addr++;
      off = 0;
    end
    if (cmd == pbfm_pkg::CMD_READ) r.read_value = acc;
    return r;
  endfunction

  function automatic plan_row_t plan_step(input logic [pbfm_pkg::CNT_W-1:0] cc,
                                          input logic [pbfm_pkg::CNT_W-1:0] rr,
                                          input logic [pbfm_pkg::KEY_W-1:0] kb,
                                          input logic cmd,
                                          input logic [pbfm_pkg::COL_W-1:0] col,
                                          input logic [pbfm_pkg::ROW_W-1:0] row,
                                          input logic [pbfm_pkg::VAL_W-1:0] val,
                                          input logic fixed,
                                          input logic [pbfm_pkg::VAL_W-1:0] want,
                                          input logic want_oor);
    plan_row_t p;
    p = '{cc, rr, kb, cmd, col, row, val, fixed, want, want_oor};
    return p;
  endfunction

  task automatic wait_idle();
    req.valid <= 1'b0;
    while (pending_fields.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] code,
                                input logic [pbfm_pkg::PDATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {code, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (code)
      pbfm_pkg::REG_COLUMN_COUNT: cfg_columns = value[pbfm_pkg::CNT_W-1:0];
      pbfm_pkg::REG_ROW_COUNT:    cfg_rows    = value[pbfm_pkg::CNT_W-1:0];
      pbfm_pkg::REG_KEY_BITS:     cfg_key     = value[pbfm_pkg::KEY_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [pbfm_pkg::CNT_W-1:0] cc,
                           input logic [pbfm_pkg::CNT_W-1:0] rr,
                           input logic [pbfm_pkg::KEY_W-1:0] kb);
    wait_idle();
    write_register(pbfm_pkg::REG_COLUMN_COUNT, {16'($urandom), cc});
    write_register(pbfm_pkg::REG_ROW_COUNT, {16'($urandom), rr});
    write_register(pbfm_pkg::REG_KEY_BITS, {26'($urandom), kb});
    settings_done++;
  endtask

  task automatic send_request(input logic cmd, input logic [pbfm_pkg::COL_W-1:0] col,
                              input logic [pbfm_pkg::ROW_W-1:0] row,
                              input logic [pbfm_pkg::VAL_W-1:0] val,
                              input logic fixed, input logic [pbfm_pkg::VAL_W-1:0] want,
                              input logic want_oor);
    field_result_t r;
    if (!quiet && $urandom_range(99) < 21) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(12, 1)) @(posedge clk);
    end
    req.valid       <= 1'b1;
    req.command     <= cmd;
    req.column      <= col;
    req.row         <= row;
    req.write_value <= val;
    do @(posedge clk); while (!req.ready);
    r = field_access(cmd, col, row, val);
    if (fixed) begin
      r.read_value   = want;
      r.out_of_range = want_oor;
    end
    pending_fields.push_back(r);
    if (r.out_of_range) rejects_sent++;
    if (cmd == pbfm_pkg::CMD_WRITE) writes_sent++;
    else reads_sent++;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk);
      rsp.ready <= quiet || ($urandom_range(99) >= 21);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("packed_bit_field_matrix_unit verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_ni && rsp.valid && rsp.ready) begin
      if (pending_fields.size() == 0) begin
        if (failures < 10)
          $display("unexpected response: read_value=%h out_of_range=%b",
                   rsp.read_value, rsp.out_of_range);
        failures++;
      end else begin
        front_field = pending_fields.pop_front();
        if (rsp.read_value !== front_field.read_value ||
            rsp.out_of_range !== front_field.out_of_range) begin
          if (failures < 10)
            $display("mismatch: expected read_value=%h out_of_range=%b, got %h %b",
                     front_field.read_value, front_field.out_of_range,
                     rsp.read_value, rsp.out_of_range);
          failures++;
        end
      end
    end
  end

  initial begin
    logic                       cmd;
    logic [pbfm_pkg::COL_W-1:0] col;
    logic [pbfm_pkg::ROW_W-1:0] row;
    logic [pbfm_pkg::CNT_W-1:0] cc, rr;
    logic [pbfm_pkg::KEY_W-1:0] kb;
    longint unsigned            pitch, fit, cmax;
    int unsigned                burst, sent_random;

    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    req.valid       = 1'b0;
    req.command     = pbfm_pkg::CMD_READ;
    req.column      = '0;
    req.row         = '0;
    req.write_value = '0;
    quiet           = 1'b0;
    failures        = 0;
    reads_sent      = 0;
    writes_sent     = 0;
    rejects_sent    = 0;
    settings_done   = 0;
    cycle_count     = 0;
    sent_random     = 0;
    cfg_columns     = 16'd64;
    cfg_rows        = 16'd64;
    cfg_key         = 6'd8;
    foreach (byte_image[i]) byte_image[i] = 8'h00;

    plan[0]  = plan_step(64, 64, 8, pbfm_pkg::CMD_READ, 0, 0, 0, 1, 32'h0, 0);
    plan[1]  = plan_step(64, 64, 8, pbfm_pkg::CMD_READ, 63, 63, 0, 1, 32'h0, 0);
    plan[2]  = plan_step(64, 64, 8, pbfm_pkg::CMD_WRITE, 63, 63, 32'hFFFF_FFFF, 1, 32'h0, 0);
    plan[3]  = plan_step(64, 64, 8, pbfm_pkg::CMD_READ, 63, 63, 0, 1, 32'hFF, 0);
    plan[4]  = plan_step(64, 64, 8, pbfm_pkg::CMD_READ, 64, 0, 0, 1, 32'h0, 1);
    plan[5]  = plan_step(64, 64, 8, pbfm_pkg::CMD_READ, 0, 64, 0, 1, 32'h0, 1);
    plan[6]  = plan_step(64, 64, 8, pbfm_pkg::CMD_WRITE, 32767, 32767, 32'hFFFF_FFFF, 1,
                         32'h0, 1);
    plan[7]  = plan_step(4, 4, 32, pbfm_pkg::CMD_WRITE, 3, 3, 32'hA5C3_0F81, 1, 32'h0, 0);
    plan[8]  = plan_step(4, 4, 32, pbfm_pkg::CMD_READ, 3, 3, 0, 1, 32'hA5C3_0F81, 0);
    plan[9]  = plan_step(16, 2, 0, pbfm_pkg::CMD_WRITE, 5, 1, 32'h3, 1, 32'h0, 0);
    plan[10] = plan_step(16, 2, 0, pbfm_pkg::CMD_READ, 5, 1, 0, 1, 32'h1, 0);
    plan[11] = plan_step(2, 1, 63, pbfm_pkg::CMD_WRITE, 1, 0, 32'h1234_5678, 1, 32'h0, 0);
    plan[12] = plan_step(2, 1, 63, pbfm_pkg::CMD_READ, 1, 0, 0, 1, 32'h1234_5678, 0);
    plan[13] = plan_step(3, 2, 31, pbfm_pkg::CMD_WRITE, 1, 1, 32'h7FFF_FFFF, 1, 32'h0, 0);
    plan[14] = plan_step(3, 2, 31, pbfm_pkg::CMD_READ, 1, 1, 0, 1, 32'h7FFF_FFFF, 0);
    plan[15] = plan_step(3, 2, 31, pbfm_pkg::CMD_READ, 2, 1, 0, 0, 32'h0, 0);
    plan[16] = plan_step(3, 2, 33, pbfm_pkg::CMD_READ, 1, 1, 0, 0, 32'h0, 0);
    plan[17] = plan_step(0, 8, 8, pbfm_pkg::CMD_READ, 0, 0, 0, 1, 32'h0, 1);
    plan[18] = plan_step(8, 0, 8, pbfm_pkg::CMD_WRITE, 0, 0, 32'h5A, 1, 32'h0, 1);
    plan[19] = plan_step(65535, 1, 1, pbfm_pkg::CMD_WRITE, 32767, 0, 32'h1, 1, 32'h0, 0);
    plan[20] = plan_step(65535, 1, 1, pbfm_pkg::CMD_READ, 32767, 0, 0, 1, 32'h1, 0);
    plan[21] = plan_step(32768, 1, 8, pbfm_pkg::CMD_READ, 32767, 0, 0, 1, 32'h0, 1);
    plan[22] = plan_step(64, 65535, 8, pbfm_pkg::CMD_READ, 0, 64, 0, 1, 32'h0, 1);
    plan[23] = plan_step(7, 3, 5, pbfm_pkg::CMD_WRITE, 6, 2, 32'hFFFF_FFFB, 1, 32'h0, 0);
    plan[24] = plan_step(7, 3, 5, pbfm_pkg::CMD_READ, 6, 2, 0, 1, 32'h1B, 0);

    repeat (11) @(posedge clk);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].cc != cfg_columns || plan[i].rr != cfg_rows || plan[i].kb != cfg_key)
        configure(plan[i].cc, plan[i].rr, plan[i].kb);
      send_request(plan[i].cmd, plan[i].col, plan[i].row, plan[i].val,
                   plan[i].fixed, plan[i].want, plan[i].want_oor);
    end

    wait_idle();
    write_register(REG_SPARE, $urandom);

    while (sent_random < RANDOM_ITEMS) begin
      kb = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(32, 1));
      cc = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(48, 1));
      rr = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(48, 1));
      configure(cc, rr, kb);
      pitch = row_pitch(cc, eff_width(kb));
      fit   = (pitch == 0) ? 1 : STORE_BYTES / pitch;
      if (fit > rr) fit = rr;
      if (fit > 32768) fit = 32768;
      if (fit == 0) fit = 1;
      cmax = (cc == 0) ? 1 : ((cc > 32768) ? 32768 : cc);
      burst = $urandom_range(140, 60);
      for (int i = 0; i < burst && sent_random < RANDOM_ITEMS; i++) begin
        quiet = (sent_random >= 700 && sent_random < 1000);
        if (sent_random == 400) wait_idle();
        cmd = 1'($urandom);
        if ($urandom_range(99) < 85) begin
          if ($urandom_range(1) == 0) begin
            col = pbfm_pkg::COL_W'($urandom_range(int'(cmax > 16 ? 16 : cmax) - 1));
            row = pbfm_pkg::ROW_W'($urandom_range(int'(fit > 8 ? 8 : fit) - 1));
          end else begin
            col = pbfm_pkg::COL_W'($urandom_range(int'(cmax) - 1));
            row = pbfm_pkg::ROW_W'($urandom_range(int'(fit) - 1));
          end
        end else begin
          col = pbfm_pkg::COL_W'($urandom);
          row = pbfm_pkg::ROW_W'($urandom);
        end
        send_request(cmd, col, row, $urandom, 1'b0, '0, 1'b0);
        sent_random++;
      end
    end

    quiet = 1'b0;
    wait_idle();
    repeat (20) @(posedge clk);
    $display("Ran %0d reads and %0d writes, %0d of them rejected, over %0d matrix settings",
             reads_sent, writes_sent, rejects_sent, settings_done);
    $display("Failures counted: %0d", failures);
    if (failures == 0) begin
      $display("packed_bit_field_matrix_unit verification clean");
    end else begin
      $display("packed_bit_field_matrix_unit verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/pbfm_pkg.sv
sv/pbfm_if.sv
sv/pbfm_ram.sv
sv/packed_bit_field_matrix_unit.sv
bench/packed_bit_field_matrix_unit_tb.sv
